// ===== design/sncs_pkg.sv =====
// ----------------------------------------------------------------------------
// sncs_pkg: shared types and constants for the spiral nearest cell search
// Holds request and result codes, the controller state and command types,
// and the datapath status bundle.
// ----------------------------------------------------------------------------
package sncs_pkg;

    // default width of the cell budget
    localparam int BUDGET_WIDTH_DEF = 16;

    // field widths of the input and result transactions
    localparam int CENTER_W = 15;
    localparam int CELL_BUDGET_W = 16;
    localparam int COORD_W = 16;

    // packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    // request type on the input tuser
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_ANSWER = 1'b1;

    // result kind on the output tuser
    localparam logic KIND_PROBE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // spiral side directions
    typedef enum logic [1:0] {
        SIDE_PX = 2'd0,
        SIDE_PY = 2'd1,
        SIDE_NX = 2'd2,
        SIDE_NY = 2'd3
    } side_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CENTER,
        ST_RING,
        ST_WALK
    } state_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_BEGIN_RING,
        OP_NEXT_RING,
        OP_NEXT_SIDE,
        OP_MOVE,
        OP_RECORD_HIT
    } op_t;

    // command bundle from controller to datapath
    typedef struct packed {
        op_t  op;
        logic emit_probe;
        logic emit_done;
        logic found;
    } cmd_t;

    // status bundle from datapath to controller
    typedef struct packed {
        logic out_free;
        logic steps_zero;
        logic phase_last;
        logic best_set;
        logic budget_pos;
        logic keep_cell;
    } stat_t;

endpackage

// ===== design/sncs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sncs_ctrl: search sequencer
// Tracks whether a search runs and which probe is outstanding, and steps the
// spiral walk one side turn, ring start or cell per cycle.
// ----------------------------------------------------------------------------
module sncs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           req_type,
    input  logic           hit,
    input  sncs_pkg::stat_t stat,
    output sncs_pkg::cmd_t  cmd,
    output sncs_pkg::state_t state
);
    import sncs_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    // input is taken only while waiting on an answer or a start
    always_comb begin
        case (state_reg)
            ST_IDLE, ST_CENTER, ST_RING: s_tready = stat.out_free;
            default:                     s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && req_type == REQ_START) state_next = ST_START;
            end
            ST_START: begin
                state_next = ST_CENTER;
            end
            ST_CENTER: begin
                if (accept) begin
                    if (req_type == REQ_START) state_next = ST_START;
                    else if (hit || !stat.budget_pos) state_next = ST_IDLE;
                    else state_next = ST_WALK;
                end
            end
            ST_RING: begin
                if (accept) begin
                    if (req_type == REQ_START) state_next = ST_START;
                    else state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (stat.steps_zero) begin
                    if (stat.phase_last && (stat.best_set || !stat.budget_pos)) begin
                        state_next = ST_IDLE;
                    end
                end else if (stat.keep_cell) begin
                    state_next = ST_RING;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd = '{op: OP_NONE, emit_probe: 1'b0, emit_done: 1'b0, found: 1'b0};
        case (state_reg)
            ST_IDLE: begin
                if (accept && req_type == REQ_START) cmd.op = OP_START;
            end
            ST_START: begin
                cmd.emit_probe = 1'b1;
            end
            ST_CENTER: begin
                if (accept) begin
                    if (req_type == REQ_START) begin
                        cmd.op = OP_START;
                    end else if (hit) begin
                        cmd.emit_done = 1'b1;
                        cmd.found = 1'b1;
                    end else if (!stat.budget_pos) begin
                        cmd.emit_done = 1'b1;
                    end else begin
                        cmd.op = OP_BEGIN_RING;
                    end
                end
            end
            ST_RING: begin
                if (accept) begin
                    if (req_type == REQ_START) cmd.op = OP_START;
                    else if (hit) cmd.op = OP_RECORD_HIT;
                end
            end
            ST_WALK: begin
                if (stat.steps_zero) begin
                    if (!stat.phase_last) begin
                        cmd.op = OP_NEXT_SIDE;
                    end else if (stat.best_set) begin
                        cmd.emit_done = 1'b1;
                        cmd.found = 1'b1;
                    end else if (stat.budget_pos) begin
                        cmd.op = OP_NEXT_RING;
                    end else begin
                        cmd.emit_done = 1'b1;
                    end
                end else begin
                    cmd.op = OP_MOVE;
                    cmd.emit_probe = stat.keep_cell;
                end
            end
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

// ===== design/sncs_dpath.sv =====
// ----------------------------------------------------------------------------
// sncs_dpath: spiral walk datapath
// Holds the center, offsets, ring extent, side counter, budget and distances,
// tracks the squared distance incrementally, and owns the result register.
// ----------------------------------------------------------------------------
module sncs_dpath #(
    parameter int BUDGET_WIDTH = sncs_pkg::BUDGET_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic signed [sncs_pkg::CENTER_W-1:0]    center_x,
    input  logic signed [sncs_pkg::CENTER_W-1:0]    center_y,
    input  logic [sncs_pkg::CELL_BUDGET_W-1:0]      cell_budget,
    input  sncs_pkg::cmd_t                          cmd,
    output sncs_pkg::stat_t                         stat,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_kind,
    output logic signed [sncs_pkg::COORD_W-1:0]     m_probe_x,
    output logic signed [sncs_pkg::COORD_W-1:0]     m_probe_y,
    output logic                                    m_found
);
    import sncs_pkg::*;

    // extent stays below about the square root of the budget
    localparam int EXT_W = BUDGET_WIDTH / 2 + 2;
    localparam int OFF_W = EXT_W + 2;
    localparam int DIST_W = 2 * EXT_W;
    localparam int COST_W = EXT_W + 2;
    localparam int BUD_W = ((BUDGET_WIDTH > COST_W) ? BUDGET_WIDTH : COST_W) + 2;
    localparam int LOAD_W = (BUDGET_WIDTH < CELL_BUDGET_W) ? BUDGET_WIDTH : CELL_BUDGET_W;

    logic signed [CENTER_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [OFF_W-1:0]    ox_reg, ox_next, oy_reg, oy_next;
    logic [EXT_W-1:0]           ext_reg, ext_next, ext_plus1, ext_plus2;
    side_t                      side_reg, side_next;
    logic [EXT_W-1:0]           steps_reg, steps_next;
    logic signed [BUD_W-1:0]    budget_reg, budget_next;
    logic [DIST_W-1:0]          best_reg, best_next, dist_reg, dist_next, dist_move;
    logic [COST_W-1:0]          cost_cur, cost_nxt;
    logic signed [DIST_W+1:0]   dx2, dy2, d_cur, d_move;
    logic                       valid_reg, valid_next;
    logic                       kind_reg, found_reg;
    logic signed [COORD_W-1:0]  px_reg, py_reg, px_calc, py_calc;

    // ring cost 4*extent+2 and derived extents
    assign ext_plus1 = ext_reg + EXT_W'(1);
    assign ext_plus2 = ext_reg + EXT_W'(2);
    assign cost_cur = {ext_reg, 2'b10};
    assign cost_nxt = {ext_plus2, 2'b10};

    // squared distance after one step along the current side
    assign dx2 = (DIST_W + 2)'(ox_reg) <<< 1;
    assign dy2 = (DIST_W + 2)'(oy_reg) <<< 1;
    assign d_cur = $signed({2'b00, dist_reg});
    always_comb begin
        case (side_reg)
            SIDE_PX: d_move = d_cur + dx2 + (DIST_W + 2)'(1);
            SIDE_PY: d_move = d_cur + dy2 + (DIST_W + 2)'(1);
            SIDE_NX: d_move = d_cur - dx2 + (DIST_W + 2)'(1);
            default: d_move = d_cur - dy2 + (DIST_W + 2)'(1);
        endcase
    end
    assign dist_move = d_move[DIST_W-1:0];

    // status back to the controller
    assign stat.out_free = !valid_reg || m_ready;
    assign stat.steps_zero = (steps_reg == '0);
    assign stat.phase_last = (side_reg == SIDE_NY);
    assign stat.best_set = (best_reg != '0);
    assign stat.budget_pos = !budget_reg[BUD_W-1] && (budget_reg != '0);
    assign stat.keep_cell = (best_reg == '0) || (dist_move < best_reg);

    // walk state update
    always_comb begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        ext_next = ext_reg;
        side_next = side_reg;
        steps_next = steps_reg;
        budget_next = budget_reg;
        best_next = best_reg;
        dist_next = dist_reg;
        case (cmd.op)
            OP_START: begin
                cx_next = center_x;
                cy_next = center_y;
                ox_next = '0;
                oy_next = '0;
                ext_next = EXT_W'(1);
                side_next = SIDE_PX;
                steps_next = '0;
                budget_next = BUD_W'(cell_budget[LOAD_W-1:0]);
                best_next = '0;
                dist_next = '0;
            end
            OP_BEGIN_RING: begin
                budget_next = budget_reg - BUD_W'(cost_cur);
                side_next = SIDE_PX;
                steps_next = ext_reg;
            end
            OP_NEXT_RING: begin
                ext_next = ext_plus2;
                budget_next = budget_reg - BUD_W'(cost_nxt);
                side_next = SIDE_PX;
                steps_next = ext_plus2;
            end
            OP_NEXT_SIDE: begin
                side_next = side_t'(side_reg + 2'd1);
                steps_next = (side_reg == SIDE_PX) ? ext_reg : ext_plus1;
            end
            OP_MOVE: begin
                case (side_reg)
                    SIDE_PX: ox_next = ox_reg + OFF_W'(1);
                    SIDE_PY: oy_next = oy_reg + OFF_W'(1);
                    SIDE_NX: ox_next = ox_reg - OFF_W'(1);
                    default: oy_next = oy_reg - OFF_W'(1);
                endcase
                steps_next = steps_reg - EXT_W'(1);
                dist_next = dist_move;
            end
            OP_RECORD_HIT: begin
                best_next = dist_reg;
            end
            default: ;
        endcase
    end

    // probe cell, wrapped to the coordinate width
    assign px_calc = COORD_W'(cx_next) + COORD_W'(ox_next);
    assign py_calc = COORD_W'(cy_next) + COORD_W'(oy_next);

    // result register valid
    always_comb begin
        if (cmd.emit_probe || cmd.emit_done) valid_next = 1'b1;
        else if (m_ready) valid_next = 1'b0;
        else valid_next = valid_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg <= '0;
            cy_reg <= '0;
            ox_reg <= '0;
            oy_reg <= '0;
            ext_reg <= EXT_W'(1);
            side_reg <= SIDE_PX;
            steps_reg <= '0;
            budget_reg <= '0;
            best_reg <= '0;
            dist_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            ext_reg <= ext_next;
            side_reg <= side_next;
            steps_reg <= steps_next;
            budget_reg <= budget_next;
            best_reg <= best_next;
            dist_reg <= dist_next;
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_probe) begin
            kind_reg <= KIND_PROBE;
            px_reg <= px_calc;
            py_reg <= py_calc;
            found_reg <= 1'b0;
        end else if (cmd.emit_done) begin
            kind_reg <= KIND_DONE;
            px_reg <= '0;
            py_reg <= '0;
            found_reg <= cmd.found;
        end
    end

    assign m_valid = valid_reg;
    assign m_kind = kind_reg;
    assign m_probe_x = px_reg;
    assign m_probe_y = py_reg;
    assign m_found = found_reg;

endmodule

// ===== design/spiral_nearest_cell_search.sv =====
// ----------------------------------------------------------------------------
// spiral_nearest_cell_search: square-spiral nearest cell search sequencer
// Emits cells to probe around a center, ring by ring, pruning cells that are
// not closer than the best hit, and reports when the search is finished.
//
//   channel  direction  tuser      tdata
//   s_       in         req_type   center_x, center_y, cell_budget, hit
//   m_       out        kind       probe_x, probe_y, found
//
// A start transaction loads the walk state, and the start state then registers
// its center probe. An answer to the center probe that ends the search yields
// the finish in the cycle after acceptance. Any other answer to a probe enters
// the walk, which ends at the next probe or the finish; the walk sequencer
// takes one side turn, ring start or pruned cell per cycle.
// Reset is synchronous; the block comes out idle with no result pending.
// A stalled result holds in the output register; input is taken again once
// that register is empty or being drained.
// ----------------------------------------------------------------------------
module spiral_nearest_cell_search #(
    parameter int BUDGET_WIDTH = sncs_pkg::BUDGET_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tuser: req_type
    input  logic                             s_tuser,
    // tdata: center_x [14:0], center_y [29:15], cell_budget [45:30], hit [46]
    input  logic [sncs_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tuser: kind
    output logic                             m_tuser,
    // tdata: probe_x [15:0], probe_y [31:16], found [32]
    output logic [sncs_pkg::M_TDATA_W-1:0]   m_tdata
);
    import sncs_pkg::*;

    cmd_t                       cmd;
    stat_t                      stat;
    state_t                     state;
    logic signed [COORD_W-1:0]  probe_x, probe_y;
    logic                       found;

    // sequencer
    sncs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .hit      (s_tdata[46]),
        .stat     (stat),
        .cmd      (cmd),
        .state    (state)
    );

    // walk datapath and result register
    sncs_dpath #(
        .BUDGET_WIDTH (BUDGET_WIDTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .center_x    (s_tdata[14:0]),
        .center_y    (s_tdata[29:15]),
        .cell_budget (s_tdata[45:30]),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_kind      (m_tuser),
        .m_probe_x   (probe_x),
        .m_probe_y   (probe_y),
        .m_found     (found)
    );

    // result packing
    assign m_tdata = {7'b0, found, probe_y, probe_x};

    // a result is never written over one that is still stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_probe || cmd.emit_done) |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while stalled");

    // a finish always returns the sequencer to idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_done |=> (state == ST_IDLE))
        else $error("sequencer not idle after finish");

    // an accepted start shows its center probe after the load cycle
    a_start_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == REQ_START) |=> ##1
        (m_tvalid && m_tuser == KIND_PROBE))
        else $error("start did not produce a center probe");

    // no input is taken while a start is loading or the walk is stepping
    a_walk_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_WALK || state == ST_START) |-> !s_tready)
        else $error("input accepted during walk");

endmodule

// ===== tb/sv/spiral_search_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spiral_search_checker: result predictor and scoreboard for the spiral search
// Watches both stream channels, walks its own copy of the square spiral for
// every accepted input transaction, queues the probe or finish result that it
// should cause, and compares each accepted output transaction field by field.
// ----------------------------------------------------------------------------
module spiral_search_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            s_tuser,
    input  logic [sncs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            m_tuser,
    input  logic [sncs_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                              mismatches,
    output int                              outstanding
);
    import sncs_pkg::*;

    // one result transaction as the block should send it
    typedef struct packed {
        logic        kind;
        logic [15:0] px;
        logic [15:0] py;
        logic        found;
    } cell_result_t;

    cell_result_t expected_cells[$];

    // predicted search state
    int    ctr_x;
    int    ctr_y;
    int    off_x;
    int    off_y;
    int    extent;
    side_t phase;
    int    steps_left;
    int    budget_rem;
    int    best_sq;
    bit    active;
    bit    at_center;

    initial mismatches = 0;

    // probe of the current cell, wrapped to the coordinate width
    function automatic cell_result_t probe_cell();
        cell_result_t r;
        int sx;
        int sy;
        sx = ctr_x + off_x;
        sy = ctr_y + off_y;
        r.kind = KIND_PROBE;
        r.px = sx[15:0];
        r.py = sy[15:0];
        r.found = 1'b0;
        return r;
    endfunction

    function automatic cell_result_t finish_search(input bit hit_seen);
        cell_result_t r;
        active = 1'b0;
        at_center = 1'b0;
        r.kind = KIND_DONE;
        r.px = '0;
        r.py = '0;
        r.found = hit_seen;
        return r;
    endfunction

    // charge the next ring to the budget, refused once the budget is spent
    function automatic bit open_ring();
        if (budget_rem <= 0)
            return 1'b0;
        budget_rem -= 4 * extent + 2;
        phase = SIDE_PX;
        steps_left = extent;
        return 1'b1;
    endfunction

    // step along the spiral until a cell worth probing or the end of the search
    task automatic walk_spiral(output cell_result_t r);
        bit settled;
        int d;
        settled = 1'b0;
        while (!settled) begin
            if (steps_left == 0) begin
                if (phase == SIDE_NY) begin
                    if (best_sq != 0) begin
                        r = finish_search(1'b1);
                        settled = 1'b1;
                    end else begin
                        extent += 2;
                        if (!open_ring()) begin
                            r = finish_search(1'b0);
                            settled = 1'b1;
                        end
                    end
                end else begin
                    phase = side_t'(phase + 1);
                    steps_left = (phase >= SIDE_NX) ? extent + 1 : extent;
                end
            end else begin
                case (phase)
                    SIDE_PX: off_x++;
                    SIDE_PY: off_y++;
                    SIDE_NX: off_x--;
                    default: off_y--;
                endcase
                steps_left--;
                d = off_x * off_x + off_y * off_y;
                // cells no closer than the best hit are skipped silently
                if (best_sq == 0 || d < best_sq) begin
                    r = probe_cell();
                    settled = 1'b1;
                end
            end
        end
    endtask

    // apply one accepted input transaction to the predicted state
    task automatic predict_search(input logic req, input logic [S_TDATA_W-1:0] data);
        cell_result_t r;
        bit has_result;
        logic [14:0] cx;
        logic [14:0] cy;
        logic [15:0] budget;
        logic hit;
        cx = data[14:0];
        cy = data[29:15];
        budget = data[45:30];
        hit = data[46];
        has_result = 1'b0;
        r = '0;
        if (req == REQ_START) begin
            ctr_x = int'($signed(cx));
            ctr_y = int'($signed(cy));
            budget_rem = int'(budget);
            off_x = 0;
            off_y = 0;
            extent = 1;
            phase = SIDE_PX;
            steps_left = 0;
            best_sq = 0;
            active = 1'b1;
            at_center = 1'b1;
            r = probe_cell();
            has_result = 1'b1;
        end else if (active) begin
            has_result = 1'b1;
            if (at_center) begin
                at_center = 1'b0;
                if (hit)
                    r = finish_search(1'b1);
                else if (!open_ring())
                    r = finish_search(1'b0);
                else
                    walk_spiral(r);
            end else begin
                if (hit)
                    best_sq = off_x * off_x + off_y * off_y;
                walk_spiral(r);
            end
        end
        if (has_result)
            expected_cells.push_back(r);
    endtask

    task automatic report_mismatch(input string field, input int exp_v, input int got_v);
        $display("%0t ns: result mismatch on %s, expected 0x%0h, got 0x%0h",
                 $realtime, field, exp_v, got_v);
        mismatches++;
    endtask

    // compare each output transaction with the oldest expectation
    task automatic check_result(input logic kind, input logic [M_TDATA_W-1:0] data);
        cell_result_t e;
        if (expected_cells.size() == 0) begin
            report_mismatch("unexpected result kind", -1, int'(kind));
        end else begin
            e = expected_cells.pop_front();
            if (kind !== e.kind)
                report_mismatch("kind", int'(e.kind), int'(kind));
            if (data[15:0] !== e.px)
                report_mismatch("probe_x", int'(e.px), int'(data[15:0]));
            if (data[31:16] !== e.py)
                report_mismatch("probe_y", int'(e.py), int'(data[31:16]));
            if (data[32] !== e.found)
                report_mismatch("found", int'(e.found), int'(data[32]));
        end
    endtask

    // watch both channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            ctr_x = 0;
            ctr_y = 0;
            off_x = 0;
            off_y = 0;
            extent = 1;
            phase = SIDE_PX;
            steps_left = 0;
            budget_rem = 0;
            best_sq = 0;
            active = 1'b0;
            at_center = 1'b0;
            expected_cells.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                predict_search(s_tuser, s_tdata);
        end
        outstanding <= expected_cells.size();
    end

endmodule

// ===== tb/sv/tb_spiral_nearest_cell_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spiral_nearest_cell_search: testbench top for the spiral cell search
// Drives whole searches: a start, then an answer to every probe the block
// sends, with hits placed or drawn at random. Also sends answers while idle
// and restarts running searches. Input bursts and output stalls are random.
// ----------------------------------------------------------------------------
module tb_spiral_nearest_cell_search;
    import sncs_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic                 s_tuser = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 m_tuser;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;

    // kinds of the result transactions seen, consumed by the search driver
    logic result_kinds[$];

    int searches_sent = 0;
    int burst_left = 0;
    int rx_mode = 0;
    int rx_phase_left = 0;

    spiral_nearest_cell_search DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    spiral_search_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tuser     (m_tuser),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // result stall pattern: free-running, random and mostly-stalled stretches
    always @(posedge aclk) begin
        if (rx_phase_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_phase_left <= $urandom_range(10, 150);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // note the kind of every result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            result_kinds.push_back(m_tuser);
    end

    // send one input transaction, in bursts with random gaps between them
    task automatic send_item(input logic req, input logic [14:0] cx, input logic [14:0] cy,
                             input logic [15:0] budget, input logic hit,
                             input bit counted);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {1'b0, hit, budget, cy, cx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        if (counted)
            searches_sent++;
    endtask

    // wait for the next result transaction and return its kind
    task automatic wait_result(output logic kind);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (result_kinds.size() == 0);
        kind = result_kinds.pop_front();
    endtask

    // one search: answer probes until the finish, or drop it after
    // max_answers answers, leaving a probe unanswered
    task automatic run_search(input logic [14:0] cx, input logic [14:0] cy,
                              input logic [15:0] budget, input int hit_pct,
                              input int first_hit, input int max_answers,
                              output bit finished);
        int n;
        logic kind;
        logic hit;
        bit busy;
        n = 0;
        busy = 1'b1;
        finished = 1'b0;
        send_item(REQ_START, cx, cy, budget, 1'($urandom_range(0, 1)), 1'b1);
        while (busy) begin
            wait_result(kind);
            if (kind == KIND_DONE) begin
                finished = 1'b1;
                busy = 1'b0;
            end else if (n == max_answers) begin
                busy = 1'b0;
            end else begin
                hit = (n == first_hit) || ($urandom_range(0, 99) < hit_pct);
                send_item(REQ_ANSWER, 15'($urandom()), 15'($urandom()), 16'($urandom()),
                          hit, 1'b1);
                n++;
            end
        end
    endtask

    // stimulus
    initial begin
        bit finished;
        logic [15:0] budget;
        int hit_pct;
        int first_hit;
        int max_answers;
        int pick;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: answer while idle
        send_item(REQ_ANSWER, 15'h7fff, 15'h7fff, 16'hffff, 1'b1, 1'b0);
        // zero budget, center miss ends not found
        run_search(15'h4000, 15'h4000, 16'd0, 0, -1, 1000, finished);
        // zero budget, center hit ends found
        run_search(15'h3fff, 15'h3fff, 16'd0, 0, 0, 1000, finished);
        // full budget, hit on the first ring, cells of the ring no closer than it pruned
        run_search(15'h3fff, 15'h4000, 16'hffff, 0, 2, 1000, finished);
        // budget below one ring cost, ring still walked in full
        run_search(15'h4000, 15'h3fff, 16'd1, 0, -1, 1000, finished);
        // start while searching drops the running search
        run_search(15'd0, 15'd0, 16'hffff, 0, -1, 1, finished);
        run_search(15'd5, -15'sd5, 16'd3, 0, 6, 1000, finished);

        // random searches
        while (searches_sent < 1250) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                budget = 16'($urandom_range(0, 40));
            else if (pick < 85)
                budget = 16'($urandom_range(0, 200));
            else
                budget = 16'($urandom());
            case ($urandom_range(0, 4))
                0: hit_pct = 0;
                1: hit_pct = 5;
                2: hit_pct = 15;
                3: hit_pct = 40;
                default: hit_pct = 100;
            endcase
            first_hit = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 30) : -1;
            if ($urandom_range(0, 9) == 0)
                max_answers = $urandom_range(0, 10);
            else if (budget > 200)
                max_answers = 80;
            else
                max_answers = 1000;
            run_search(15'($urandom()), 15'($urandom()), budget, hit_pct, first_hit,
                       max_answers, finished);
            // stray answer once the block is idle again
            if (finished && $urandom_range(0, 4) == 0)
                send_item(REQ_ANSWER, 15'($urandom()), 15'($urandom()), 16'($urandom()),
                          1'($urandom_range(0, 1)), 1'b0);
        end

        // drain
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("spiral_nearest_cell_search test passed");
        else
            $display("spiral_nearest_cell_search test failed");
        $finish;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("spiral_nearest_cell_search test failed");
        $finish;
    end

endmodule
